/* design/opa_pkg.sv */
// Package: shared types and constants for the object pool allocator.
`default_nettype none

package opa_pkg;

  // Pool geometry
  localparam int POOL_SIZE = 256;
  localparam int HANDLE_W  = 8;
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  // Command codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_TRY   = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // Command transaction
  typedef struct packed {
    logic [1:0]          opcode;
    logic [HANDLE_W-1:0] handle_in;
  } opa_cmd_t;

  // Result transaction
  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [1:0]          status;
  } opa_result_t;

  // Free-list memory request from the control logic
  typedef struct packed {
    logic                we;
    logic                pop;
    logic [HANDLE_W-1:0] waddr;
    logic [HANDLE_W-1:0] wdata;
    logic [HANDLE_W-1:0] raddr;
  } opa_qport_t;

endpackage

`default_nettype wire

/* design/object_pool_allocator_unit.sv */
// Top level: handle pool allocator with a FIFO free list.
//
// One command transaction per clock: busy stays low, so start may be held high
// every cycle. Each command gives exactly one result. Each result sits on result
// with done high for a single cycle, after passing the input register and then
// the result register. Results cannot be held off: the receiver must take each
// one in its cycle. Allocate reuses the oldest freed handle, else the next fresh
// handle, else reports exhaustion; try allocate only reuses; deallocate checks
// the allocated bitmap. The bitmap clears at reset with no clearing pass, so the
// block takes commands as soon as reset is released. The free list sits in a RAM
// whose read address is the next head position, so its read data holds the head.
`default_nettype none

module object_pool_allocator_unit
  import opa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire opa_cmd_t cmd,
  output logic          done,
  output opa_result_t   result
);

  logic                req_valid;
  opa_cmd_t            req;
  opa_result_t         result_next;
  opa_qport_t          qport;
  logic [HANDLE_W-1:0] q_rdata;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req <= cmd;
  end

  // Decision logic and state
  opa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .q_rdata     (q_rdata),
    .qport       (qport),
    .result_next (result_next)
  );

  // Free-list storage
  opa_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (POOL_SIZE)
  ) u_free_ram (
    .clk   (clk),
    .we    (qport.we),
    .waddr (qport.waddr),
    .wdata (qport.wdata),
    .raddr (qport.raddr),
    .rdata (q_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Checks
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(qport.we && qport.pop))
    else $error("free list pushed and popped in one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> (result.handle_out == '0))
    else $error("nonzero handle with error status");

  a_invalid_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && (result_next.status == ST_INVALID) |-> (req.opcode == OP_FREE))
    else $error("invalid status on a command that is not deallocate");

  a_empty_try: assert property (@(posedge clk) disable iff (rst)
    req_valid && (result_next.status == ST_EMPTY) |-> (req.opcode == OP_TRY))
    else $error("empty status on a command that is not try allocate");

endmodule

`default_nettype wire

/* design/opa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module opa_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, read returns the old contents on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/opa_ctrl.sv */
// Allocator control: bitmap, free-list pointers, fresh counter and decision logic.
`default_nettype none

module opa_ctrl
  import opa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire opa_cmd_t            req,
  input  wire logic [HANDLE_W-1:0] q_rdata,
  output opa_qport_t               qport,
  output opa_result_t              result_next
);

  logic [POOL_SIZE-1:0] alloc_map;
  logic [POOL_SIZE-1:0] alloc_map_next;
  logic [HANDLE_W-1:0]  queue_head;
  logic [HANDLE_W-1:0]  queue_head_next;
  logic [HANDLE_W-1:0]  queue_tail;
  logic [HANDLE_W-1:0]  queue_tail_next;
  logic [CNT_W-1:0]     queue_count;
  logic [CNT_W-1:0]     queue_count_next;
  logic [CNT_W-1:0]     fresh_count;
  logic [CNT_W-1:0]     fresh_count_next;
  logic                 fwd_valid;
  logic                 fwd_valid_next;
  logic [HANDLE_W-1:0]  fwd_data;
  logic [HANDLE_W-1:0]  head_data;
  logic                 have_freed;
  logic                 have_fresh;
  logic                 pop;
  logic                 push;

  // Oldest freed handle: bypass covers a push that landed on the read address
  assign head_data  = fwd_valid ? fwd_data : q_rdata;
  assign have_freed = (queue_count != '0);
  assign have_fresh = (fresh_count < CNT_W'(POOL_SIZE));

  // Decide the outcome of the registered command
  always_comb begin
    alloc_map_next   = alloc_map;
    queue_count_next = queue_count;
    fresh_count_next = fresh_count;
    queue_tail_next  = queue_tail;
    pop              = 1'b0;
    push             = 1'b0;
    result_next      = '{handle_out: '0, status: ST_OK};
    if (req_valid) begin
      unique case (req.opcode)
        OP_ALLOC: begin
          if (have_freed) begin
            pop                     = 1'b1;
            result_next.handle_out  = head_data;
            alloc_map_next[head_data] = 1'b1;
          end else if (have_fresh) begin
            result_next.handle_out  = fresh_count[HANDLE_W-1:0];
            alloc_map_next[fresh_count[HANDLE_W-1:0]] = 1'b1;
            fresh_count_next        = fresh_count + CNT_W'(1);
          end else begin
            result_next.status = ST_EXHAUSTED;
          end
        end
        OP_TRY: begin
          if (have_freed) begin
            pop                     = 1'b1;
            result_next.handle_out  = head_data;
            alloc_map_next[head_data] = 1'b1;
          end else begin
            result_next.status = ST_EMPTY;
          end
        end
        OP_FREE: begin
          if (alloc_map[req.handle_in]) begin
            if (queue_count < CNT_W'(POOL_SIZE)) begin
              push                          = 1'b1;
              alloc_map_next[req.handle_in] = 1'b0;
              queue_tail_next               = queue_tail + HANDLE_W'(1);
            end
          end else begin
            result_next.status = ST_INVALID;
          end
        end
        default: begin
          // unused code: no state change, zero result
        end
      endcase
      if (pop) begin
        queue_count_next = queue_count - CNT_W'(1);
      end else if (push) begin
        queue_count_next = queue_count + CNT_W'(1);
      end
    end
  end

  assign queue_head_next = pop ? queue_head + HANDLE_W'(1) : queue_head;
  assign fwd_valid_next  = push && (queue_tail == queue_head_next);

  // Free-list memory request: always read ahead at the next head position
  always_comb begin
    qport.we    = push;
    qport.pop   = pop;
    qport.waddr = queue_tail;
    qport.wdata = req.handle_in;
    qport.raddr = queue_head_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_map   <= '0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      fresh_count <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      alloc_map   <= alloc_map_next;
      queue_head  <= queue_head_next;
      queue_tail  <= queue_tail_next;
      queue_count <= queue_count_next;
      fresh_count <= fresh_count_next;
      fwd_valid   <= fwd_valid_next;
    end
  end

  // Bypass data
  always_ff @(posedge clk) begin
    fwd_data <= req.handle_in;
  end

endmodule

`default_nettype wire

/* tb/object_pool_allocator_unit_tb.sv */
// Testbench for the object pool allocator, checked against a behavioral pool model.
`default_nettype none

module object_pool_allocator_unit_tb
  import opa_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode with no defined operation
  localparam logic [1:0] OP_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  opa_cmd_t    cmd = '0;
  logic        done;
  opa_result_t result;

  object_pool_allocator_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pool model state
  bit [POOL_SIZE-1:0]  live_map;
  logic [HANDLE_W-1:0] freed_fifo[$];
  int                  fresh_next;

  // Results predicted but not yet seen
  opa_result_t pending_results[$];

  int errors;
  int burst_left;
  int status_hits[4];
  int reuse_grants;
  int fresh_grants;
  int sent_cmds;

  // Mismatch report
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Model of one command: updates pool state and returns the expected result
  function automatic opa_result_t pool_model_step(input opa_cmd_t c);
    opa_result_t r;
    r.handle_out = '0;
    r.status     = ST_OK;
    case (c.opcode)
      OP_ALLOC, OP_TRY: begin
        if (freed_fifo.size() != 0) begin
          r.handle_out = freed_fifo.pop_front();
          live_map[r.handle_out] = 1'b1;
          reuse_grants++;
        end else if (c.opcode == OP_TRY) begin
          r.status = ST_EMPTY;
        end else if (fresh_next < POOL_SIZE) begin
          r.handle_out = fresh_next[HANDLE_W-1:0];
          live_map[fresh_next] = 1'b1;
          fresh_next++;
          fresh_grants++;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      OP_FREE: begin
        if (int'(c.handle_in) < POOL_SIZE && live_map[c.handle_in]) begin
          if (freed_fifo.size() < POOL_SIZE) begin
            freed_fifo.push_back(c.handle_in);
            live_map[c.handle_in] = 1'b0;
          end
        end else begin
          r.status = ST_INVALID;
        end
      end
      default: ;  // unused opcode: no state change
    endcase
    status_hits[r.status]++;
    return r;
  endfunction

  // Any live handle, or -1 if none is live
  function automatic int pick_live();
    int base;
    int idx;
    base = $urandom_range(0, POOL_SIZE - 1);
    for (int i = 0; i < POOL_SIZE; i++) begin
      idx = (base + i) % POOL_SIZE;
      if (live_map[idx]) return idx;
    end
    return -1;
  endfunction

  // Random handle field
  function automatic logic [HANDLE_W-1:0] rand_handle();
    return HANDLE_W'($urandom_range(0, 255));
  endfunction

  // Sender pacing: bursts of random length, random gaps between them
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      idle_cycles($urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Send one command transaction and record its expected result
  task automatic send_cmd(input logic [1:0] op, input logic [HANDLE_W-1:0] h);
    opa_cmd_t c;
    c.opcode    = op;
    c.handle_in = h;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(pool_model_step(c));
    sent_cmds++;
    pace();
  endtask

  // Release a live handle, or a random one when nothing is live
  task automatic free_live();
    int h;
    h = pick_live();
    if (h < 0) h = $urandom_range(0, 255);
    send_cmd(OP_FREE, h[HANDLE_W-1:0]);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    opa_result_t exp_r;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result handle=%0d status=%0d",
                                  result.handle_out, result.status));
      end else begin
        exp_r = pending_results.pop_front();
        if (result.handle_out !== exp_r.handle_out)
          report_mismatch($sformatf("handle_out got %0d exp %0d",
                                    result.handle_out, exp_r.handle_out));
        if (result.status !== exp_r.status)
          report_mismatch($sformatf("status got %0d exp %0d",
                                    result.status, exp_r.status));
      end
    end
  end

  // Directed corner cases on a fresh pool
  task automatic test_directed_cases();
    send_cmd(OP_TRY, 8'h00);    // nothing freed yet
    send_cmd(OP_FREE, 8'h00);   // never allocated
    send_cmd(OP_FREE, 8'hFF);   // top handle, never allocated
    send_cmd(OP_NONE, 8'hFF);   // unused opcode
    send_cmd(OP_ALLOC, 8'h55);  // handle_in ignored
    send_cmd(OP_ALLOC, 8'hAA);
    send_cmd(OP_ALLOC, 8'h00);
    send_cmd(OP_FREE, 8'h01);
    send_cmd(OP_FREE, 8'h01);   // double release
    send_cmd(OP_FREE, 8'h00);
    send_cmd(OP_TRY, 8'hFF);    // oldest freed first
    send_cmd(OP_ALLOC, 8'h00);
    send_cmd(OP_ALLOC, 8'h00);  // back to fresh handles
    send_cmd(OP_TRY, 8'h00);
    send_cmd(OP_FREE, 8'h02);
    send_cmd(OP_FREE, 8'h03);
    send_cmd(OP_ALLOC, 8'h00);
    send_cmd(OP_TRY, 8'h00);
    send_cmd(OP_NONE, 8'h00);
    drain_results();
  endtask

  // Mixed random traffic, mostly well formed
  task automatic test_random_churn(input int n, input int alloc_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
        send_cmd(OP_ALLOC, rand_handle());
      else if (r < alloc_pct + 12)
        send_cmd(OP_TRY, rand_handle());
      else if (r < 90)
        free_live();
      else if (r < 95)
        send_cmd(OP_NONE, rand_handle());
      else
        send_cmd(OP_FREE, rand_handle());  // often invalid
    end
    drain_results();
  endtask

  // Create every handle, then run the pool dry and refill a pair
  task automatic test_pool_exhaustion();
    int r;
    while (fresh_next < POOL_SIZE) begin
      r = $urandom_range(0, 99);
      if (r < 80)      send_cmd(OP_ALLOC, rand_handle());
      else if (r < 92) free_live();
      else             send_cmd(OP_TRY, rand_handle());
    end
    while (freed_fifo.size() != 0) send_cmd(OP_ALLOC, rand_handle());
    send_cmd(OP_ALLOC, 8'h00);  // exhausted
    send_cmd(OP_ALLOC, 8'hFF);
    send_cmd(OP_TRY, 8'h00);    // empty
    send_cmd(OP_FREE, 8'hFF);
    send_cmd(OP_FREE, 8'h00);
    send_cmd(OP_ALLOC, 8'h00);
    send_cmd(OP_ALLOC, 8'h00);
    send_cmd(OP_ALLOC, 8'h00);  // exhausted again
    drain_results();
  endtask

  // Main sequence
  initial begin
    errors       = 0;
    burst_left   = 0;
    fresh_next   = 0;
    reuse_grants = 0;
    fresh_grants = 0;
    sent_cmds    = 0;
    live_map     = '0;
    for (int i = 0; i < 4; i++) status_hits[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_churn(350, 40);
    test_pool_exhaustion();
    test_random_churn(500, 35);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d commands: %0d fresh grants, %0d reuses, %0d ok results",
             sent_cmds, fresh_grants, reuse_grants, status_hits[ST_OK]);
    $display("Error paths hit: %0d empty, %0d invalid release, %0d exhausted",
             status_hits[ST_EMPTY], status_hits[ST_INVALID], status_hits[ST_EXHAUSTED]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
